// ----- design/cau_pkg.sv -----
`default_nettype none

package cau_pkg;

  // field widths are fixed by the item format
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  // remainder holds the magnitude shifted by up to WORD_BITS-1 fraction bits
  localparam int REM_BITS  = 3 * WORD_BITS;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5
  } op_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  typedef struct packed {
    logic [2:0] operation;
    word_t      a_real;
    word_t      a_imag;
    word_t      b_real;
    word_t      b_imag;
  } req_t;

  typedef struct packed {
    word_t result_real;
    word_t result_imag;
    logic  divide_by_zero;
    logic  overflow;
  } rsp_t;

  // products of the operands, first pipeline stage
  typedef struct packed {
    logic [2:0] operation;
    word_t      a_real;
    word_t      a_imag;
    word_t      b_real;
    word_t      b_imag;
    prod_t      p_rr;
    prod_t      p_ii;
    prod_t      p_ri;
    prod_t      p_ir;
    prod_t      p_bb;
    prod_t      p_jj;
  } prod_stage_t;

  // result for everything but divide, already saturated
  typedef struct packed {
    logic  is_div;
    logic  dz;
    word_t re;
    word_t im;
    logic  ovf;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [PROD_BITS-1:0] den;
    sum_t                 nr;
    sum_t                 ni;
  } comb_stage_t;

  typedef struct packed {
    side_t                side;
    logic [PROD_BITS-1:0] den;
    logic [REM_BITS-1:0]  rem_re;
    logic [REM_BITS-1:0]  rem_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [WORD_BITS-1:0] q_re;
    logic [WORD_BITS-1:0] q_im;
  } div_stage_t;

endpackage

`default_nettype wire

// ----- design/cau_product_stage.sv -----
`default_nettype none

module cau_product_stage (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire cau_pkg::req_t        din,
  output cau_pkg::prod_stage_t      dout
);

  cau_pkg::prod_t p_rr, p_ii, p_ri, p_ir, p_bb, p_jj;

  // signed 32x32 products, exact at twice the word width
  assign p_rr = din.a_real * din.b_real;
  assign p_ii = din.a_imag * din.b_imag;
  assign p_ri = din.a_real * din.b_imag;
  assign p_ir = din.a_imag * din.b_real;
  assign p_bb = din.b_real * din.b_real;
  assign p_jj = din.b_imag * din.b_imag;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.operation <= din.operation;
      dout.a_real    <= din.a_real;
      dout.a_imag    <= din.a_imag;
      dout.b_real    <= din.b_real;
      dout.b_imag    <= din.b_imag;
      dout.p_rr      <= p_rr;
      dout.p_ii      <= p_ii;
      dout.p_ri      <= p_ri;
      dout.p_ir      <= p_ir;
      dout.p_bb      <= p_bb;
      dout.p_jj      <= p_jj;
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_combine_stage.sv -----
`default_nettype none

module cau_combine_stage #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire cau_pkg::prod_stage_t din,
  output cau_pkg::comb_stage_t      dout
);

  localparam int W = cau_pkg::WORD_BITS;
  localparam int S = cau_pkg::SUM_BITS;

  cau_pkg::sum_t  v_re, v_im, mul_re, mul_im;
  cau_pkg::side_t side;
  logic           ovf_re, ovf_im;
  cau_pkg::word_t sat_re, sat_im;
  logic [cau_pkg::PROD_BITS-1:0] den;

  assign mul_re = (S'(din.p_rr) - S'(din.p_ii)) >>> FRACTION_BITS;
  assign mul_im = (S'(din.p_ri) + S'(din.p_ir)) >>> FRACTION_BITS;

  always_comb begin
    v_re = '0;
    v_im = '0;
    unique case (din.operation)
      cau_pkg::OP_ADD: begin
        v_re = S'(din.a_real) + S'(din.b_real);
        v_im = S'(din.a_imag) + S'(din.b_imag);
      end
      cau_pkg::OP_SUB: begin
        v_re = S'(din.a_real) - S'(din.b_real);
        v_im = S'(din.a_imag) - S'(din.b_imag);
      end
      cau_pkg::OP_MUL: begin
        v_re = mul_re;
        v_im = mul_im;
      end
      cau_pkg::OP_NEG: begin
        v_re = -S'(din.a_real);
        v_im = -S'(din.a_imag);
      end
      cau_pkg::OP_CONJ: begin
        v_re = S'(din.a_real);
        v_im = -S'(din.a_imag);
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
  end

  // saturate: value fits when all bits above the word sign agree
  always_comb begin
    ovf_re = !((&v_re[S-1:W-1]) || !(|v_re[S-1:W-1]));
    ovf_im = !((&v_im[S-1:W-1]) || !(|v_im[S-1:W-1]));
    sat_re = ovf_re ? (v_re[S-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                    : v_re[W-1:0];
    sat_im = ovf_im ? (v_im[S-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                    : v_im[W-1:0];
  end

  // squared modulus, both squares are non-negative
  assign den = din.p_bb + din.p_jj;

  always_comb begin
    side.is_div = (din.operation == cau_pkg::OP_DIV);
    side.dz     = side.is_div && (den == '0);
    side.re     = sat_re;
    side.im     = sat_im;
    side.ovf    = ovf_re || ovf_im;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.side <= side;
      dout.den  <= den;
      dout.nr   <= S'(din.p_rr) + S'(din.p_ii);
      dout.ni   <= S'(din.p_ir) - S'(din.p_ri);
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_div_setup.sv -----
`default_nettype none

module cau_div_setup #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire cau_pkg::comb_stage_t din,
  output cau_pkg::div_stage_t       dout
);

  localparam int W = cau_pkg::WORD_BITS;
  localparam int P = cau_pkg::PROD_BITS;
  localparam int R = cau_pkg::REM_BITS;

  cau_pkg::sum_t       mag_re, mag_im;
  logic [R-1:0]        rem_re, rem_im, lim;

  // numerator magnitudes fit in the product width
  assign mag_re = din.nr[P] ? -din.nr : din.nr;
  assign mag_im = din.ni[P] ? -din.ni : din.ni;
  assign rem_re = R'(mag_re[P-1:0]) << FRACTION_BITS;
  assign rem_im = R'(mag_im[P-1:0]) << FRACTION_BITS;
  // quotient of a word width or more always saturates
  assign lim    = R'(din.den) << W;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.side   <= din.side;
      dout.den    <= din.den;
      dout.rem_re <= rem_re;
      dout.rem_im <= rem_im;
      dout.neg_re <= din.nr[P];
      dout.neg_im <= din.ni[P];
      dout.big_re <= (rem_re >= lim);
      dout.big_im <= (rem_im >= lim);
      dout.q_re   <= '0;
      dout.q_im   <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_div_cell.sv -----
`default_nettype none

module cau_div_cell #(
  parameter int STEP = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire cau_pkg::div_stage_t din,
  output cau_pkg::div_stage_t      dout
);

  localparam int R   = cau_pkg::REM_BITS;
  localparam int BIT = cau_pkg::WORD_BITS - 1 - STEP;

  logic [R-1:0] trial;
  logic         take_re, take_im;
  cau_pkg::div_stage_t nxt;

  // one restoring step per cell, both parts in parallel
  assign trial   = R'(din.den) << BIT;
  assign take_re = (din.rem_re >= trial);
  assign take_im = (din.rem_im >= trial);

  always_comb begin
    nxt = din;
    if (take_re) begin
      nxt.rem_re    = din.rem_re - trial;
      nxt.q_re[BIT] = 1'b1;
    end
    if (take_im) begin
      nxt.rem_im    = din.rem_im - trial;
      nxt.q_im[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/complex_arithmetic_unit_core.sv -----
`default_nettype none

// complex arithmetic unit, signed fixed point operands
// req channel: one transfer carries an operation code and operands a and b
// rsp channel: one transfer per request with the result, a divide_by_zero
//   flag and an overflow flag (set when either part saturated)
// the datapath is a pipeline: products, sums and saturation, divide setup,
//   then a row of WORD_BITS divider cells (one quotient bit per cell, all
//   operations ride the row), then the output register
// the pipeline has 36 register stages, from the product stage to the output register
// throughput: one transfer per cycle while the receiver takes every result; the divider row is fully pipelined
// reset clears every stage valid bit; payload registers are not reset
// when the receiver stalls the output register holds; stages behind it keep
//   filling any bubbles, so req_ready falls only once every stage is full
module complex_arithmetic_unit_core #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire cau_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output cau_pkg::rsp_t        rsp
);

  localparam int W   = cau_pkg::WORD_BITS;
  // product, combine, setup, divider cells, output register
  localparam int NST = W + 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  cau_pkg::prod_stage_t prod_q;
  cau_pkg::comb_stage_t comb_q;
  cau_pkg::div_stage_t  cell_q [0:W];

  // a stage takes new data when it is empty or its content moves on
  assign en[NST-1] = !vld[NST-1] || rsp_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign req_ready = en[0];
  assign rsp_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  cau_product_stage u_prod (
    .clk  (clk),
    .en   (en[0]),
    .din  (req),
    .dout (prod_q)
  );

  cau_combine_stage #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_comb (
    .clk  (clk),
    .en   (en[1]),
    .din  (prod_q),
    .dout (comb_q)
  );

  cau_div_setup #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_setup (
    .clk  (clk),
    .en   (en[2]),
    .din  (comb_q),
    .dout (cell_q[0])
  );

  // divider row, cell s decides quotient bit W-1-s
  for (genvar s = 0; s < W; s++) begin : g_cell
    cau_div_cell #(
      .STEP (s)
    ) u_cell (
      .clk  (clk),
      .en   (en[s+3]),
      .din  (cell_q[s]),
      .dout (cell_q[s+1])
    );
  end

  // final selection and quotient saturation
  cau_pkg::div_stage_t fin;
  cau_pkg::word_t      q_re, q_im;
  logic                ov_re, ov_im;
  cau_pkg::rsp_t       rsp_next;

  localparam cau_pkg::word_t MAXW = {1'b0, {(W-1){1'b1}}};
  localparam cau_pkg::word_t MINW = {1'b1, {(W-1){1'b0}}};

  assign fin = cell_q[W];

  always_comb begin
    // positive quotient fits below 2^(W-1), negative up to 2^(W-1)
    priority if (fin.big_re) begin
      ov_re = 1'b1;
      q_re  = fin.neg_re ? MINW : MAXW;
    end else if (!fin.neg_re && fin.q_re[W-1]) begin
      ov_re = 1'b1;
      q_re  = MAXW;
    end else if (fin.neg_re && fin.q_re[W-1] && (|fin.q_re[W-2:0])) begin
      ov_re = 1'b1;
      q_re  = MINW;
    end else begin
      ov_re = 1'b0;
      q_re  = fin.neg_re ? -fin.q_re : fin.q_re;
    end
    priority if (fin.big_im) begin
      ov_im = 1'b1;
      q_im  = fin.neg_im ? MINW : MAXW;
    end else if (!fin.neg_im && fin.q_im[W-1]) begin
      ov_im = 1'b1;
      q_im  = MAXW;
    end else if (fin.neg_im && fin.q_im[W-1] && (|fin.q_im[W-2:0])) begin
      ov_im = 1'b1;
      q_im  = MINW;
    end else begin
      ov_im = 1'b0;
      q_im  = fin.neg_im ? -fin.q_im : fin.q_im;
    end
  end

  always_comb begin
    priority if (fin.side.dz) begin
      // zero divisor gives zero and no overflow
      rsp_next.result_real    = '0;
      rsp_next.result_imag    = '0;
      rsp_next.divide_by_zero = 1'b1;
      rsp_next.overflow       = 1'b0;
    end else if (fin.side.is_div) begin
      rsp_next.result_real    = q_re;
      rsp_next.result_imag    = q_im;
      rsp_next.divide_by_zero = 1'b0;
      rsp_next.overflow       = ov_re || ov_im;
    end else begin
      rsp_next.result_real    = fin.side.re;
      rsp_next.result_imag    = fin.side.im;
      rsp_next.divide_by_zero = 1'b0;
      rsp_next.overflow       = fin.side.ovf;
    end
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |->
      rsp.result_real == '0 && rsp.result_imag == '0 && !rsp.overflow)
    else $error("divide by zero result not clean");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty output register");

  a_ovf_saturated : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |->
      rsp.result_real == MAXW || rsp.result_real == MINW ||
      rsp.result_imag == MAXW || rsp.result_imag == MINW)
    else $error("overflow flagged without a saturated part");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

  // operation codes with no defined operation, they give zero and no flags
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int FRACTION_BITS = 16;

  typedef logic signed [127:0] wide_t;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  cau_pkg::req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  cau_pkg::rsp_t  rsp;

  // results still owed by the unit, oldest first
  cau_pkg::rsp_t  owed_results[$];
  int    error_count;
  int    cycle_count;
  int    result_count;
  int    op_count[8];
  bit    rsp_stall_on;

  complex_arithmetic_unit_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // clamp an exact value to a signed word, flag any clamping
  function automatic cau_pkg::word_t clamp_word(input wide_t v, inout bit clamped);
    wide_t top;
    wide_t bottom;
    top    = 128'sh7fffffff;
    bottom = -128'sh80000000;
    if (v > top) begin
      clamped = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < bottom) begin
      clamped = 1'b1;
      return 32'sh80000000;
    end
    return cau_pkg::word_t'(v[31:0]);
  endfunction

  // exact complex arithmetic in 128 bits, then saturation
  function automatic cau_pkg::rsp_t complex_result(input cau_pkg::req_t r);
    wide_t ar;
    wide_t ai;
    wide_t br;
    wide_t bi;
    wide_t re;
    wide_t im;
    wide_t den;
    bit    clamped;
    cau_pkg::rsp_t  res;
    ar = r.a_real;
    ai = r.a_imag;
    br = r.b_real;
    bi = r.b_imag;
    re = 0;
    im = 0;
    clamped = 1'b0;
    res.divide_by_zero = 1'b0;
    case (r.operation)
      cau_pkg::OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        // arithmetic shift rounds toward minus infinity
        re = (ar * br - ai * bi) >>> FRACTION_BITS;
        im = (ar * bi + ai * br) >>> FRACTION_BITS;
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.divide_by_zero = 1'b1;
        end else begin
          // signed division truncates toward zero
          re = ((ar * br + ai * bi) <<< FRACTION_BITS) / den;
          im = ((ai * br - ar * bi) <<< FRACTION_BITS) / den;
        end
      end
      cau_pkg::OP_NEG: begin
        re = -ar;
        im = -ai;
      end
      cau_pkg::OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      default: begin
      end
    endcase
    res.result_real = clamp_word(re, clamped);
    res.result_imag = clamp_word(im, clamped);
    res.overflow    = clamped;
    return res;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side: random stalls, mostly short, a few long
  initial begin
    int pick;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 99);
      if (!rsp_stall_on || pick < 70) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b0;
        if (pick > 96) repeat ($urandom_range(10, 60)) @(posedge clk);
        else repeat ($urandom_range(0, 3)) @(posedge clk);
      end
    end
  end

  // result checking, one compare per rsp transfer
  always @(posedge clk) begin
    cau_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      result_count <= result_count + 1;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        error_count <= error_count + 1;
      end else begin
        want = owed_results.pop_front();
        if (rsp.result_real !== want.result_real || rsp.result_imag !== want.result_imag
            || rsp.divide_by_zero !== want.divide_by_zero
            || rsp.overflow !== want.overflow) begin
          $display("%0t: mismatch expected re=%h im=%h dz=%b ovf=%b", $time,
                   want.result_real, want.result_imag, want.divide_by_zero, want.overflow);
          $display("%0t:          actual   re=%h im=%h dz=%b ovf=%b", $time,
                   rsp.result_real, rsp.result_imag, rsp.divide_by_zero, rsp.overflow);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // idle cycles after a transfer: mostly none, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // one req transfer; the expectation is queued at the accepting edge
  task automatic send_item(input cau_pkg::req_t item, input bit with_gaps);
    int gap;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    owed_results.push_back(complex_result(item));
    op_count[item.operation]++;
    gap = with_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic cau_pkg::req_t make_item(input logic [2:0] op,
                                              input cau_pkg::word_t ar,
                                              input cau_pkg::word_t ai,
                                              input cau_pkg::word_t br,
                                              input cau_pkg::word_t bi);
    cau_pkg::req_t r;
    r.operation = op;
    r.a_real    = ar;
    r.a_imag    = ai;
    r.b_real    = br;
    r.b_imag    = bi;
    return r;
  endfunction

  // operand mix: full range, modest values, tiny values and corner values
  function automatic cau_pkg::word_t random_word();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return cau_pkg::word_t'($urandom);
    if (p < 65) return cau_pkg::word_t'($signed($urandom_range(0, 32'h0008_0000))
                                        - 32'sh0004_0000);
    if (p < 80) return cau_pkg::word_t'($signed($urandom_range(0, 64)) - 32);
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0001_0000;
      3: return -32'sh0001_0000;
      default: return 32'sh0;
    endcase
  endfunction

  task automatic test_directed();
    cau_pkg::word_t w_min;
    cau_pkg::word_t w_max;
    w_min = 32'sh8000_0000;
    w_max = 32'sh7fff_ffff;
    // extreme and ordinary operands for each operation
    send_item(make_item(cau_pkg::OP_ADD, w_max, w_min, w_max, w_min), 1'b0);
    send_item(make_item(cau_pkg::OP_ADD, 32'sh0001_8000, -32'sh2, 32'sh3, 32'sh4), 1'b0);
    send_item(make_item(cau_pkg::OP_SUB, w_min, w_max, w_max, w_min), 1'b0);
    send_item(make_item(cau_pkg::OP_SUB, 32'sh5, 32'sh6, 32'sh7, 32'sh8), 1'b0);
    send_item(make_item(cau_pkg::OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                        -32'sh0001_0000), 1'b0);
    send_item(make_item(cau_pkg::OP_MUL, w_min, w_min, w_min, w_min), 1'b0);
    send_item(make_item(cau_pkg::OP_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0), 1'b0);
    send_item(make_item(cau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0, 32'sh0002_0000, 32'sh0),
              1'b0);
    send_item(make_item(cau_pkg::OP_DIV, -32'sh0003_0000, 32'sh0001_0000, 32'sh0,
                        32'sh0007_0000), 1'b0);
    send_item(make_item(cau_pkg::OP_DIV, w_max, w_min, 32'sh1, 32'sh0), 1'b0);
    send_item(make_item(cau_pkg::OP_DIV, w_min, w_min, w_min, w_min), 1'b0);
    // zero divisor
    send_item(make_item(cau_pkg::OP_DIV, 32'sh0001_0000, w_max, 32'sh0, 32'sh0), 1'b0);
    send_item(make_item(cau_pkg::OP_DIV, 32'sh0, 32'sh0, 32'sh0, 32'sh0), 1'b0);
    // negating the most negative value saturates
    send_item(make_item(cau_pkg::OP_NEG, w_min, w_max, w_max, w_min), 1'b0);
    send_item(make_item(cau_pkg::OP_NEG, 32'sh1234_5678, -32'sh1, 32'sh0, 32'sh0), 1'b0);
    send_item(make_item(cau_pkg::OP_CONJ, w_max, w_min, 32'sh0, 32'sh0), 1'b0);
    send_item(make_item(cau_pkg::OP_CONJ, w_min, w_max, 32'sh1, 32'sh1), 1'b0);
    // undefined codes
    send_item(make_item(OP_SPARE_LO, w_max, w_max, w_max, w_max), 1'b0);
    send_item(make_item(OP_SPARE_HI, w_min, w_min, w_min, w_min), 1'b0);
    wait_for_results();
  endtask

  task automatic test_random(input int count);
    cau_pkg::req_t  item;
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      item = make_item(op, random_word(), random_word(), random_word(), random_word());
      if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
        item.b_real = 32'sh0;
        item.b_imag = 32'sh0;
      end
      // stretches with no idling at all
      send_item(item, (i % 300) >= 100);
      // sender holds off until the pipe is empty
      if (i % 450 == 449) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    rsp_stall_on = 1'b0;
    for (int i = 0; i < 80; i++)
      send_item(make_item(3'($urandom_range(0, 5)), random_word(), random_word(),
                          random_word(), random_word()), 1'b0);
    wait_for_results();
    rsp_stall_on = 1'b1;
  endtask

  initial begin
    req_valid    = 1'b0;
    req          = '0;
    rst          = 1'b1;
    error_count  = 0;
    cycle_count  = 0;
    result_count = 0;
    rsp_stall_on = 1'b1;
    foreach (op_count[k]) op_count[k] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_random(RANDOM_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d results: add %0d sub %0d mul %0d div %0d neg %0d conj %0d",
             result_count, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5]);
    $display("undefined codes %0d, random idles and stalls on both channels",
             op_count[6] + op_count[7]);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
